@@ design/vmn_pkg.sv @@
// ---------------------------------------------------------------------------
// vmn_pkg
// Shared types and constants for the vertex map to normal map block.
// ---------------------------------------------------------------------------
package vmn_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_COORD_BITS = 32;

   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH_EPSILON = 2'd2;

   localparam logic FUNC_VERTEX = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   localparam int NORM_BITS = 18;

   typedef struct packed {
      logic        func;
      logic [31:0] vertex_x;
      logic [31:0] vertex_y;
      logic [31:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic [NORM_BITS-1:0] normal_x;
      logic [NORM_BITS-1:0] normal_y;
      logic [NORM_BITS-1:0] normal_z;
      logic                 normal_valid;
      logic                 frame_last;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture the neighbors and start the math
      logic step;      // not used by the datapath
      logic capture;   // return the datapath to idle once the result is taken
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic invalid;   // neighbor depth test or zero length
      logic phase_done;
   } sts_type;

endpackage

@@ design/vertex_map_to_normal_map.sv @@
// ---------------------------------------------------------------------------
// vertex_map_to_normal_map
// Streaming vertex map to normal map conversion.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one vertex (func = vertex) or one flush tick per transaction.
//   rsp_* carries one normal per pixel; the result for pixel p appears once
//   pixel p + frame_width + 1 (or a flush tick) has been taken, so a frame ends
//   with frame_width + 1 flush transactions.
//   csr_* writes frame_width, frame_height and depth_epsilon while idle; a
//   geometry write restarts the frame.
//   One transaction is handled at a time. An item without a result is accepted,
//   then waits for the registered line store read of the next column.
//   A rejected normal (near-zero depth) goes from the load state straight to
//   the invalid phase; a zero cross product is found after the scaling shifts,
//   the cross product and the 32-step square root; a valid normal also takes
//   three 48-step restoring divides in the datapath.
//   The result register holds a finished normal while the receiver stalls;
//   no new transaction is taken until it is delivered.
//   Reset returns counters and the window to zero and registers to their
//   defaults; line stores are not cleared.
// ---------------------------------------------------------------------------
module vertex_map_to_normal_map
   import vmn_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT + 2) + 1;
   localparam int PB = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
   localparam int VB = 3 * COORD_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_MATH = 4'b0100,
      ST_OUT  = 4'b1000
   } st_type;

   st_type st_ff, st_in;

   logic [9:0]  fw_ff;
   logic [10:0] fh_ff;
   logic [15:0] eps_ff;
   logic [CB:0] col_ff;
   logic [RB-1:0] row_ff;
   logic [PB-1:0] p_ff, q_ff;
   logic [CB:0] ox_ff;
   logic [RB-1:0] oy_ff;
   logic [CB:0] oxs_ff;
   logic [RB-1:0] oys_ff;
   logic [VB-1:0] upper_mem [MAX_WIDTH];
   logic [VB-1:0] middle_mem [MAX_WIDTH];
   logic [VB-1:0] up_rd_ff, mid_rd_ff;
   logic          rd_ok_ff;
   logic [VB-1:0] win_ff [3][3];
   logic [VB-1:0] lf_ff, rt_ff, up_ff, dn_ff;
   logic          last_ff;
   cmd_type       cmd;
   sts_type       sts;
   logic [NORM_BITS-1:0] nx, ny, nz;

   // clamped geometry
   logic [CB:0]   w;
   logic [RB-1:0] h;
   logic [PB-1:0] total;
   always_comb begin
      w = (fw_ff == '0) ? (CB+1)'(1) :
          (32'(fw_ff) > MAX_WIDTH ? (CB+1)'(MAX_WIDTH) : (CB+1)'(fw_ff));
      h = (fh_ff == '0) ? RB'(1) :
          (32'(fh_ff) > MAX_HEIGHT ? RB'(MAX_HEIGHT) : RB'(fh_ff));
   end
   always_ff @(posedge clock) total <= PB'(w) * PB'(h);

   logic draining, flush, take, advance, emit;
   logic [VB-1:0] nv;
   logic [CB-1:0] ic;
   assign draining = p_ff >= total;
   assign flush    = req_data.func == FUNC_FLUSH;
   assign take     = req_valid && req_ready;
   assign advance  = take && !(!draining && flush);
   assign nv = draining ? '0 : {req_data.vertex_x[COORD_BITS-1:0],
                                req_data.vertex_y[COORD_BITS-1:0],
                                req_data.vertex_z[COORD_BITS-1:0]};
   assign ic = col_ff[CB-1:0];
   assign emit = advance && (p_ff >= PB'(w) + PB'(1));

   // line stores with registered reads of the current column
   always_ff @(posedge clock) begin
      if (advance) begin
         upper_mem[ic]  <= mid_rd_ff;
         middle_mem[ic] <= nv;
      end
      up_rd_ff  <= upper_mem[ic];
      mid_rd_ff <= middle_mem[ic];
   end

   // read data is current once the registered read has seen a stable column
   always_ff @(posedge clock) begin
      if (reset) rd_ok_ff <= 1'b0;
      else       rd_ok_ff <= !(advance || csr_write);
   end

   // window, counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 10'd320; fh_ff <= 11'd240; eps_ff <= 16'd1;
         col_ff <= '0; row_ff <= '0; p_ff <= '0; q_ff <= '0;
         ox_ff <= '0; oy_ff <= '0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   fw_ff <= csr_data[9:0];
            CSR_FRAME_HEIGHT:  fh_ff <= csr_data[10:0];
            CSR_DEPTH_EPSILON: eps_ff <= csr_data;
            default: ;
         endcase
         if (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT) begin
            col_ff <= '0; row_ff <= '0; p_ff <= '0; q_ff <= '0;
            ox_ff <= '0; oy_ff <= '0;
         end
      end else if (advance) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up_rd_ff;
         win_ff[1][2] <= mid_rd_ff;
         win_ff[2][2] <= nv;
         p_ff <= p_ff + PB'(1);
         if (col_ff + (CB+1)'(1) >= w) begin
            col_ff <= '0; row_ff <= row_ff + RB'(1);
         end else col_ff <= col_ff + (CB+1)'(1);
         if (emit) begin
            if (q_ff == total - PB'(1)) begin
               col_ff <= '0; row_ff <= '0; p_ff <= '0; q_ff <= '0;
               ox_ff <= '0; oy_ff <= '0;
            end else begin
               q_ff <= q_ff + PB'(1);
               if (ox_ff + (CB+1)'(1) >= w) begin
                  ox_ff <= '0; oy_ff <= oy_ff + RB'(1);
               end else ox_ff <= ox_ff + (CB+1)'(1);
            end
         end
      end
   end

   // position of the emitted pixel (captured before counters advance)
   always_ff @(posedge clock) if (emit) begin oxs_ff <= ox_ff; oys_ff <= oy_ff; end

   // neighbor selection with border clamping, latched for the math
   always_ff @(posedge clock) begin
      if (emit) last_ff <= (q_ff == total - PB'(1));
      if (st_ff == ST_LOAD) begin
         lf_ff <= (oxs_ff == '0) ? win_ff[1][1] : win_ff[1][0];
         rt_ff <= (oxs_ff == w - (CB+1)'(1)) ? win_ff[1][1] : win_ff[1][2];
         up_ff <= (oys_ff == '0) ? win_ff[1][1] : win_ff[0][1];
         dn_ff <= (oys_ff == h - RB'(1)) ? win_ff[1][1] : win_ff[2][1];
      end
   end

   // controller
   always_comb begin
      st_in = st_ff;
      cmd   = '0;
      unique case (st_ff)
         ST_IDLE: if (emit) st_in = ST_LOAD;
         ST_LOAD: st_in = ST_MATH;
         ST_MATH: begin
            cmd.load = 1'b1;
            cmd.step = 1'b1;
            if (sts.phase_done) st_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) begin
            cmd.capture = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   assign req_ready = (st_ff == ST_IDLE) && rd_ok_ff;
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_data.normal_x     = nx;
   assign rsp_data.normal_y     = ny;
   assign rsp_data.normal_z     = nz;
   assign rsp_data.normal_valid = !sts.invalid;
   assign rsp_data.frame_last   = last_ff;

   vmn_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .eps(eps_ff),
      .lf(lf_ff), .rt(rt_ff), .up(up_ff), .dn(dn_ff),
      .nx(nx), .ny(ny), .nz(nz));

   // a result is never offered while a new transaction can be taken
   a_excl: assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("result and request overlap");
   // an invalid normal carries zero x and z components
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.normal_valid |-> rsp_data.normal_x == '0 && rsp_data.normal_z == '0)
      else $error("invalid normal not zero");
   // a delivered result returns the block to idle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("no return to idle");

endmodule

@@ design/vmn_datapath.sv @@
// ---------------------------------------------------------------------------
// vmn_datapath
// Normal math: differences, scaling, cross product, root and divide.
// ---------------------------------------------------------------------------
module vmn_datapath
   import vmn_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [15:0]            eps,
   input  logic [3*COORD_BITS-1:0] lf,
   input  logic [3*COORD_BITS-1:0] rt,
   input  logic [3*COORD_BITS-1:0] up,
   input  logic [3*COORD_BITS-1:0] dn,
   output logic [NORM_BITS-1:0]   nx,
   output logic [NORM_BITS-1:0]   ny,
   output logic [NORM_BITS-1:0]   nz
);

   localparam int DB = COORD_BITS + 1;

   typedef enum logic [9:0] {
      PH_IDLE  = 10'b0000000001,
      PH_SCLA  = 10'b0000000010,
      PH_MUL1  = 10'b0000000100,
      PH_MUL2  = 10'b0000001000,
      PH_SCLX  = 10'b0000010000,
      PH_SQ    = 10'b0000100000,
      PH_SQRT  = 10'b0001000000,
      PH_DIV   = 10'b0010000000,
      PH_DONE  = 10'b0100000000,
      PH_INV   = 10'b1000000000
   } ph_type;

   ph_type ph_ff, ph_in;

   logic signed [DB-1:0] a_ff [3];
   logic signed [DB-1:0] b_ff [3];
   logic signed [48:0]   p_ff [6];
   logic signed [49:0]   x_ff [3];
   logic [63:0]          n_ff, r_ff, bit_ff;
   logic [5:0]           cnt_ff;
   logic [1:0]           sel_ff;
   logic [47:0]          num_ff, quo_ff;
   logic [31:0]          len_ff;
   logic [NORM_BITS-1:0] res_ff [3];

   function automatic logic signed [COORD_BITS-1:0] comp(
      input logic [3*COORD_BITS-1:0] v, input int k);
      comp = v[(2-k)*COORD_BITS +: COORD_BITS];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? -v : v;
   endfunction

   function automatic logic [30:0] mag31(input logic signed [63:0] v);
      logic [63:0] m;
      m = mag64(v);
      mag31 = m[30:0];
   endfunction

   // near-zero depth test
   logic bad_z;
   always_comb begin
      logic [63:0] ml, mr, mu, md;
      ml = mag64(64'(comp(lf, 2)));
      mr = mag64(64'(comp(rt, 2)));
      mu = mag64(64'(comp(up, 2)));
      md = mag64(64'(comp(dn, 2)));
      bad_z = (ml < 64'(eps)) || (mr < 64'(eps)) || (mu < 64'(eps)) || (md < 64'(eps));
   end

   // max magnitude helpers for the scaling shifts (one shift per cycle)
   logic [63:0] ma, mb, mx;
   always_comb begin
      logic [63:0] t0, t1, t2;
      t0 = mag64(64'(a_ff[0])); t1 = mag64(64'(a_ff[1])); t2 = mag64(64'(a_ff[2]));
      ma = t0 | t1 | t2;
      t0 = mag64(64'(b_ff[0])); t1 = mag64(64'(b_ff[1])); t2 = mag64(64'(b_ff[2]));
      mb = t0 | t1 | t2;
      t0 = mag64(64'(x_ff[0])); t1 = mag64(64'(x_ff[1])); t2 = mag64(64'(x_ff[2]));
      mx = t0 | t1 | t2;
   end

   function automatic logic signed [63:0] shr1(input logic signed [63:0] v);
      logic [63:0] m;
      m = mag64(v) >> 1;
      shr1 = v[63] ? -$signed(m) : $signed(m);
   endfunction

   // sum of squares of the scaled cross product magnitudes (each below 2^30)
   logic [63:0] sum_sq;
   assign sum_sq = 64'(p_ff[0][30:0]) * 64'(p_ff[0][30:0]) +
                   64'(p_ff[1][30:0]) * 64'(p_ff[1][30:0]) +
                   64'(p_ff[2][30:0]) * 64'(p_ff[2][30:0]);

   // divide operands
   logic [63:0] cur_x;
   always_comb begin
      unique case (sel_ff)
         2'd0:    cur_x = 64'(x_ff[0]);
         2'd1:    cur_x = 64'(x_ff[1]);
         default: cur_x = 64'(x_ff[2]);
      endcase
   end

   always_comb begin
      ph_in = ph_ff;
      unique case (ph_ff)
         PH_IDLE: if (cmd.load) ph_in = bad_z ? PH_INV : PH_SCLA;
         PH_SCLA: if (ma < 64'd16777216 && mb < 64'd16777216) ph_in = PH_MUL1;
         PH_MUL1: ph_in = PH_MUL2;
         PH_MUL2: ph_in = PH_SCLX;
         PH_SCLX: if (mx < 64'd1073741824) ph_in = PH_SQ;
         PH_SQ:   ph_in = PH_SQRT;
         PH_SQRT: if (bit_ff == '0) ph_in = (r_ff == '0) ? PH_INV : PH_DIV;
         PH_DIV:  if (cnt_ff == 6'd0 && sel_ff == 2'd2) ph_in = PH_DONE;
         PH_DONE: if (cmd.capture) ph_in = PH_IDLE;
         PH_INV:  if (cmd.capture) ph_in = PH_IDLE;
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ph_ff <= PH_IDLE;
      else       ph_ff <= ph_in;
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (ph_ff)
         PH_IDLE: begin
            for (int k = 0; k < 3; k++) begin
               a_ff[k] <= DB'(comp(dn, k)) - DB'(comp(up, k));
               b_ff[k] <= DB'(comp(rt, k)) - DB'(comp(lf, k));
            end
         end
         PH_SCLA: begin
            if (ma >= 64'd16777216)
               for (int k = 0; k < 3; k++) a_ff[k] <= DB'(shr1(64'(a_ff[k])));
            if (mb >= 64'd16777216)
               for (int k = 0; k < 3; k++) b_ff[k] <= DB'(shr1(64'(b_ff[k])));
         end
         PH_MUL1: begin
            p_ff[0] <= 49'(a_ff[1]) * 49'(b_ff[2]);
            p_ff[1] <= 49'(a_ff[2]) * 49'(b_ff[0]);
            p_ff[2] <= 49'(a_ff[0]) * 49'(b_ff[1]);
            p_ff[3] <= 49'(a_ff[2]) * 49'(b_ff[1]);
            p_ff[4] <= 49'(a_ff[0]) * 49'(b_ff[2]);
            p_ff[5] <= 49'(a_ff[1]) * 49'(b_ff[0]);
         end
         PH_MUL2: begin
            x_ff[0] <= 50'(p_ff[0]) - 50'(p_ff[3]);
            x_ff[1] <= 50'(p_ff[1]) - 50'(p_ff[4]);
            x_ff[2] <= 50'(p_ff[2]) - 50'(p_ff[5]);
         end
         PH_SCLX: begin
            if (mx >= 64'd1073741824)
               for (int k = 0; k < 3; k++) x_ff[k] <= 50'(shr1(64'(x_ff[k])));
            else
               for (int k = 0; k < 3; k++)
                  p_ff[k] <= 49'(mag31(64'(x_ff[k])));
         end
         PH_SQ: begin
            n_ff   <= sum_sq;
            r_ff   <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         PH_SQRT: begin
            if (bit_ff != '0) begin
               if (n_ff >= r_ff + bit_ff) begin
                  n_ff <= n_ff - (r_ff + bit_ff);
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               len_ff <= r_ff[31:0];
               sel_ff <= 2'd0;
               cnt_ff <= 6'd47;
               n_ff   <= '0;
               num_ff <= {mag31(64'(x_ff[0])), 16'd0} + 48'(r_ff[31:1]);
               quo_ff <= '0;
            end
         end
         PH_DIV: begin
            // restoring divide, one quotient bit per cycle
            logic [63:0] rem;
            rem = {n_ff[62:0], num_ff[cnt_ff]};
            if (rem >= 64'(len_ff)) begin
               n_ff <= rem - 64'(len_ff);
               quo_ff[cnt_ff] <= 1'b1;
            end else begin
               n_ff <= rem;
            end
            if (cnt_ff == 6'd0) begin
               logic [47:0] q;
               q = quo_ff | 48'(rem >= 64'(len_ff));
               res_ff[sel_ff] <= cur_x[63] ? NORM_BITS'(-q) : NORM_BITS'(q);
               if (sel_ff != 2'd2) begin
                  sel_ff <= sel_ff + 2'd1;
                  cnt_ff <= 6'd47;
                  n_ff   <= '0;
                  quo_ff <= '0;
                  num_ff <= {mag31(sel_ff == 2'd0 ? 64'(x_ff[1]) : 64'(x_ff[2])),
                             16'd0} + 48'(len_ff[31:1]);
               end
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
         default: ;
      endcase
   end

   assign sts.invalid    = (ph_ff == PH_INV);
   assign sts.phase_done = (ph_ff == PH_DONE) || (ph_ff == PH_INV);
   assign nx = (ph_ff == PH_DONE) ? res_ff[0] : '0;
   assign ny = (ph_ff == PH_DONE) ? res_ff[1] : '0;
   assign nz = (ph_ff == PH_DONE) ? res_ff[2] : '0;

   logic unused_ok;
   assign unused_ok = cmd.step;

endmodule

@@ sim/vertex_map_to_normal_map_tb.sv @@
// ---------------------------------------------------------------------------
// vertex_map_to_normal_map_tb
// Self-checking testbench: streams vertex frames of many geometries through
// the block, predicts every normal in a local fixed-point model, and compares
// each returned normal field by field with random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_map_to_normal_map_tb;
   import vmn_pkg::*;

   localparam int  MAX_W      = DEF_MAX_WIDTH;
   localparam int  MAX_H      = DEF_MAX_HEIGHT;
   localparam int  CYCLE_CAP  = 5000000;
   localparam int  SETTLE     = 300;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } vec_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_write;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   vertex_map_to_normal_map u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   req_type vertex_queue[$];
   rsp_type normal_queue[$];
   int      mismatches  = 0;
   int      cycle_count = 0;
   bit      quiet       = 0;   // no idling on either side while set
   bit      req_taken   = 0;
   int      req_gap     = 0;
   int      rsp_gap     = 0;

   // Predictor state
   int      cfg_width   = 320;
   int      cfg_height  = 240;
   int      cfg_epsilon = 1;
   vec_type row_above[MAX_W];
   vec_type row_mid[MAX_W];
   vec_type win[3][3];
   int      in_col;
   int      in_row;
   int      out_pos;

   // Random gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint shr_mag(longint v, int s);
      return v < 0 ? -((-v) >>> s) : (v >>> s);
   endfunction

   // Shift all components right until each magnitude is below 2^bits
   function automatic vec_type shrink(vec_type v, int bits);
      longint m;
      int     s;
      m = mag(v.x);
      s = 0;
      if (mag(v.y) > m) m = mag(v.y);
      if (mag(v.z) > m) m = mag(v.z);
      while (s < 63 && (m >>> s) >= (longint'(1) << bits)) s++;
      v.x = shr_mag(v.x, s);
      v.y = shr_mag(v.y, s);
      v.z = shr_mag(v.z, s);
      return v;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint unit_part(longint c, longint len);
      longint q;
      q = (mag(c) * 65536 + len / 2) / len;
      return c < 0 ? -q : q;
   endfunction

   function automatic void clear_counters();
      in_col  = 0;
      in_row  = 0;
      out_pos = 0;
   endfunction

   function automatic void config_apply(logic [CSR_IDX_BITS-1:0] idx,
                                        logic [CSR_DATA_BITS-1:0] val);
      if (idx == CSR_FRAME_WIDTH) begin
         cfg_width = val[9:0];
         clear_counters();
      end else if (idx == CSR_FRAME_HEIGHT) begin
         cfg_height = val[10:0];
         clear_counters();
      end else if (idx == CSR_DEPTH_EPSILON) begin
         cfg_epsilon = val;
      end
   endfunction

   // Advance the window by one transaction; returns 1 with the expected normal
   function automatic bit normal_predict(req_type it, output rsp_type o);
      int      w, h, total, p, q, ox, oy, col;
      bit      draining;
      vec_type nv, c, lf, rt, up, dn, a, b, x;
      longint  nx, ny, nz, len;
      bit      ok;
      w = cfg_width < 1 ? 1 : (cfg_width > MAX_W ? MAX_W : cfg_width);
      h = cfg_height < 1 ? 1 : (cfg_height > MAX_H ? MAX_H : cfg_height);
      total = w * h;
      p = in_row * w + in_col;
      draining = p >= total;
      o = '0;
      if (!draining && it.func == FUNC_FLUSH) return 0;
      nv = '{0, 0, 0};
      if (!draining) begin
         nv.x = longint'($signed(it.vertex_x));
         nv.y = longint'($signed(it.vertex_y));
         nv.z = longint'($signed(it.vertex_z));
      end
      col = in_col;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = row_above[col];
      win[1][2] = row_mid[col];
      win[2][2] = nv;
      row_above[col] = row_mid[col];
      row_mid[col] = nv;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (p < w + 1) return 0;

      q  = out_pos;
      ox = q % w;
      oy = q / w;
      c  = win[1][1];
      lf = ox == 0 ? c : win[1][0];
      rt = ox == w - 1 ? c : win[1][2];
      up = oy == 0 ? c : win[0][1];
      dn = oy == h - 1 ? c : win[2][1];
      nx = 0;
      ny = 0;
      nz = 0;
      ok = 0;
      if (!(mag(lf.z) < cfg_epsilon || mag(rt.z) < cfg_epsilon ||
            mag(up.z) < cfg_epsilon || mag(dn.z) < cfg_epsilon)) begin
         a = '{dn.x - up.x, dn.y - up.y, dn.z - up.z};
         b = '{rt.x - lf.x, rt.y - lf.y, rt.z - lf.z};
         a = shrink(a, 24);
         b = shrink(b, 24);
         x.x = a.y * b.z - a.z * b.y;
         x.y = a.z * b.x - a.x * b.z;
         x.z = a.x * b.y - a.y * b.x;
         x = shrink(x, 30);
         len = int_sqrt(x.x * x.x + x.y * x.y + x.z * x.z);
         if (len != 0) begin
            nx = unit_part(x.x, len);
            ny = unit_part(x.y, len);
            nz = unit_part(x.z, len);
            ok = 1;
         end
      end
      o.normal_x     = nx[NORM_BITS-1:0];
      o.normal_y     = ny[NORM_BITS-1:0];
      o.normal_z     = nz[NORM_BITS-1:0];
      o.normal_valid = ok;
      o.frame_last   = 1'b0;
      out_pos++;
      if (q == total - 1) begin
         o.frame_last = 1'b1;
         clear_counters();
      end
      return 1;
   endfunction

   // Request driver
   always @(negedge clock) begin
      logic    v;
      req_type d;
      v = req_valid;
      d = req_data;
      if (reset) begin
         v = 1'b0;
      end else if (!req_valid || req_taken) begin
         v = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (vertex_queue.size() > 0) begin
            d = vertex_queue.pop_front();
            v = 1'b1;
            req_gap = pick_gap();
         end
      end
      req_valid <= v;
      req_data  <= d;
   end

   // Response back-pressure
   always @(negedge clock) begin
      logic r;
      r = 1'b1;
      if (rsp_gap > 0) begin
         rsp_gap--;
         r = 1'b0;
      end else if (!reset && $urandom_range(99) < 20) begin
         rsp_gap = pick_gap();
         r = rsp_gap == 0;
      end
      rsp_ready <= r;
   end

   // Monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin
      rsp_type e;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         if (normal_predict(req_data, e)) normal_queue.push_back(e);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (normal_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected normal %p", rsp_data);
         end else begin
            e = normal_queue.pop_front();
            if (rsp_data.normal_x !== e.normal_x || rsp_data.normal_y !== e.normal_y ||
                rsp_data.normal_z !== e.normal_z ||
                rsp_data.normal_valid !== e.normal_valid ||
                rsp_data.frame_last !== e.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   task automatic csr_put(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      config_apply(idx, val);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (vertex_queue.size() > 0 || req_valid || normal_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type it;
      it.func     = FUNC_VERTEX;
      it.vertex_x = x;
      it.vertex_y = y;
      it.vertex_z = z;
      return it;
   endfunction

   function automatic req_type make_flush();
      req_type it;
      it = make_vertex($urandom, $urandom, $urandom);
      it.func = FUNC_FLUSH;
      return it;
   endfunction

   // One frame of w x h pixels plus the drain; style picks the surface shape
   task automatic push_frame(int w, int h, int style, bit noisy);
      logic [31:0] x, y, z;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (noisy && $urandom_range(99) < 5) vertex_queue.push_back(make_flush());
            case (style)
               0: begin
                  x = (c << 16) + $urandom_range(0, 16'hFFFF) - 32'h8000;
                  y = (r << 16) + $urandom_range(0, 16'hFFFF) - 32'h8000;
                  z = 32'h0002_0000 + $urandom_range(0, 20'hFFFFF);
                  if ($urandom_range(99) < 4) z = $urandom_range(0, 3);
               end
               1: begin
                  x = $urandom;
                  y = $urandom;
                  z = $urandom;
               end
               default: begin
                  x = 32'h0001_0000;
                  y = 32'hFFFF_0000;
                  z = 32'h0003_0000;
               end
            endcase
            vertex_queue.push_back(make_vertex(x, y, z));
         end
      end
      for (int i = 0; i <= w; i++) begin
         if (noisy && $urandom_range(99) < 10)
            vertex_queue.push_back(make_vertex($urandom, $urandom, $urandom));
         else
            vertex_queue.push_back(make_flush());
      end
   endtask

   initial begin
      int sent;
      int w, h;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data  = '0;
      for (int i = 0; i < MAX_W; i++) begin
         row_above[i] = '{0, 0, 0};
         row_mid[i]   = '{0, 0, 0};
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = '{0, 0, 0};
      clear_counters();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: 3x3 with extreme coordinates, flush mid-frame, vertex while draining
      quiet = 1;
      csr_put(CSR_FRAME_WIDTH, 16'd3);
      csr_put(CSR_FRAME_HEIGHT, 16'd3);
      csr_put(CSR_DEPTH_EPSILON, 16'd0);
      vertex_queue.push_back(make_flush());
      vertex_queue.push_back(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      vertex_queue.push_back(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      vertex_queue.push_back(make_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
      vertex_queue.push_back(make_flush());
      vertex_queue.push_back(make_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000));
      vertex_queue.push_back(make_vertex(32'h0001_0000, 32'h0002_0000, 32'h0000_0000));
      vertex_queue.push_back(make_vertex(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000));
      vertex_queue.push_back(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      vertex_queue.push_back(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      vertex_queue.push_back(make_vertex(32'h1234_5678, 32'h8765_4321, 32'h0002_0000));
      vertex_queue.push_back(make_vertex($urandom, $urandom, $urandom));
      for (int i = 0; i < 3; i++) vertex_queue.push_back(make_flush());
      wait_idle();
      // degenerate surface with a large depth threshold
      csr_put(CSR_DEPTH_EPSILON, 16'hFFFF);
      push_frame(3, 2, 2, 0);
      wait_idle();
      // abandoned frame: geometry write restarts it
      push_frame(4, 1, 0, 0);
      void'(vertex_queue.pop_back());
      void'(vertex_queue.pop_back());
      void'(vertex_queue.pop_back());
      void'(vertex_queue.pop_back());
      void'(vertex_queue.pop_back());
      wait_idle();
      quiet = 0;

      // Geometry extremes, including out-of-range register values
      csr_put(CSR_DEPTH_EPSILON, 16'd1);
      csr_put(CSR_FRAME_WIDTH, 16'd0);
      csr_put(CSR_FRAME_HEIGHT, 16'd0);
      push_frame(1, 1, 0, 1);
      wait_idle();
      // oversized geometry; the partial frame is abandoned by the next write
      csr_put(CSR_FRAME_WIDTH, 16'd1023);
      csr_put(CSR_FRAME_HEIGHT, 16'd2047);
      for (int i = 0; i < 20; i++)
         vertex_queue.push_back(make_vertex($urandom, $urandom, $urandom));
      wait_idle();

      // Random phases, mostly small frames
      sent = 0;
      while (sent < 600) begin
         w = $urandom_range(99) < 85 ? $urandom_range(1, 8) : $urandom_range(9, 24);
         h = $urandom_range(1, 6);
         quiet = $urandom_range(99) < 15;
         csr_put(CSR_FRAME_WIDTH, 16'(w));
         csr_put(CSR_FRAME_HEIGHT, 16'(h));
         case ($urandom_range(3))
            0: csr_put(CSR_DEPTH_EPSILON, 16'd0);
            1: csr_put(CSR_DEPTH_EPSILON, 16'($urandom_range(0, 16'hFFFF)));
            default: csr_put(CSR_DEPTH_EPSILON, 16'($urandom_range(1, 4)));
         endcase
         repeat ($urandom_range(1, 3)) begin
            push_frame(w, h, $urandom_range(99) < 80 ? 0 : ($urandom_range(3) == 0 ? 2 : 1),
                       $urandom_range(99) < 30);
            sent += w * h + w + 1;
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/vmn_pkg.sv
design/vmn_datapath.sv
design/vertex_map_to_normal_map.sv
sim/vertex_map_to_normal_map_tb.sv
